// File: src/udpfsc_pkg.sv
package udpfsc_pkg;

	// field widths fixed by the packet header format
	localparam int IDX_W   = 10;
	localparam int STAGE_W = 5;
	localparam int LEN_W   = 16;
	localparam int WORD_W  = 16;

	typedef logic [STAGE_W-1:0] stage_t;

	// stage codes with a meaning of their own
	localparam stage_t ST_IDLE     = 5'd0;
	localparam stage_t ST_DETECTED = 5'd19;
	localparam stage_t ST_EXCLUDED = 5'd20;

	// signature lead words
	localparam logic [WORD_W-1:0] W_010B = 16'h010b;
	localparam logic [WORD_W-1:0] W_0115 = 16'h0115;
	localparam logic [WORD_W-1:0] W_010C = 16'h010c;
	localparam logic [WORD_W-1:0] W_01C9 = 16'h01c9;
	localparam logic [WORD_W-1:0] W_0165 = 16'h0165;
	localparam logic [WORD_W-1:0] W_0101 = 16'h0101;
	localparam logic [WORD_W-1:0] W_0102 = 16'h0102;
	localparam logic [WORD_W-1:0] W_01CA = 16'h01ca;
	localparam logic [WORD_W-1:0] W_0166 = 16'h0166;

	// signature payload lengths
	localparam logic [LEN_W-1:0] L_16    = 16'd16;
	localparam logic [LEN_W-1:0] L_32    = 16'd32;
	localparam logic [LEN_W-1:0] L_64    = 16'd64;
	localparam logic [LEN_W-1:0] L_88    = 16'd88;
	localparam logic [LEN_W-1:0] L_104   = 16'd104;
	localparam logic [LEN_W-1:0] L_136   = 16'd136;
	localparam logic [LEN_W-1:0] L_LARGE = 16'd100;

	typedef enum logic [1:0] {
		VERDICT_PENDING,
		VERDICT_DETECTED,
		VERDICT_EXCLUDED
	} verdict_t;

	// result of one table update
	typedef struct packed {
		stage_t   stage;
		verdict_t verdict;
	} step_res_t;

endpackage

// File: src/udp_flow_signature_classifier.sv
// Per-flow packet classifier on a stream interface.
// Slave side: one word per packet header (flow index, start bit, payload
// length, lead word in s_tdata; UDP flag and upstream HTTP hit in s_tuser).
// Master side: one word per accepted packet, in order, with the flow index,
// the flow's stage after this packet and the verdict (pending, detected,
// excluded) in m_tuser.
// Each packet does one read-modify-write of a stage table in block RAM: the
// read is issued when the word is accepted, the new stage is written back as
// the result moves into the output register, with forwarding from the write
// just made. A word passes the stage 1 register and the output register to
// reach m_tvalid; one word is accepted every cycle while the output is
// drained, for any flow mix. When m_tready is low with a result waiting,
// the pipeline holds and s_tready drops; nothing is lost.
// After reset the table is swept to zero, one entry a cycle, over all
// FLOW_ENTRIES entries; s_tready stays low during that sweep. Flow indexes
// at or above FLOW_ENTRIES use the entry flow_index modulo FLOW_ENTRIES.
module udp_flow_signature_classifier #(
	parameter int FLOW_ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// flow_index[9:0], start_flow[10], payload_length[26:11], lead_word[42:27]
	input  logic [47:0] s_tdata,
	// is_udp[0], http_hit[1]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// flow_out[9:0], stage_out[14:10]
	output logic [15:0] m_tdata,
	// verdict[1:0]
	output logic [1:0]  m_tuser
);

	localparam int SLOT_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
	localparam int IDX_W  = udpfsc_pkg::IDX_W;
	localparam int LEN_W  = udpfsc_pkg::LEN_W;
	localparam int WORD_W = udpfsc_pkg::WORD_W;

	logic [IDX_W-1:0]   in_flow;
	logic [IDX_W-1:0]   rem;
	logic [SLOT_W-1:0]  in_slot;
	logic               adv;
	logic               in_acc;

	logic               clearing_q;
	logic [SLOT_W-1:0]  clr_addr_q;

	logic               valid_s1;
	logic [SLOT_W-1:0]  slot_s1;
	logic [IDX_W-1:0]   flow_s1;
	logic               start_s1;
	logic               udp_s1;
	logic [LEN_W-1:0]   len_s1;
	logic [WORD_W-1:0]  word_s1;
	logic               hit_s1;

	logic               fwd_valid_q;
	logic [SLOT_W-1:0]  fwd_addr_q;
	udpfsc_pkg::stage_t fwd_stage_q;

	udpfsc_pkg::stage_t rd_stage;
	udpfsc_pkg::stage_t cur_stage;
	udpfsc_pkg::step_res_t res;

	logic               m_valid_q;
	logic [IDX_W-1:0]   out_flow_q;
	udpfsc_pkg::stage_t out_stage_q;
	udpfsc_pkg::verdict_t out_verdict_q;

	logic               ram_we;
	logic [SLOT_W-1:0]  ram_waddr;
	udpfsc_pkg::stage_t ram_wdata;

	assign in_flow = s_tdata[IDX_W-1:0];

	// flow index modulo table size by restoring subtraction of shifted constants
	always_comb begin
		rem = in_flow;
		for (int k = IDX_W - 1; k >= 0; k--) begin
			if ((longint'(FLOW_ENTRIES) << k) < (longint'(1) << IDX_W)) begin
				if (rem >= IDX_W'(longint'(FLOW_ENTRIES) << k)) begin
					rem = rem - IDX_W'(longint'(FLOW_ENTRIES) << k);
				end
			end
		end
	end

	generate
		if (SLOT_W >= IDX_W) begin : g_slot_wide
			assign in_slot = SLOT_W'(rem);
		end else begin : g_slot_narrow
			assign in_slot = rem[SLOT_W-1:0];
		end
	endgenerate

	// pipeline advances whenever the output register is free or being drained
	assign adv      = !m_valid_q || m_tready;
	assign s_tready = adv && !clearing_q;
	assign in_acc   = s_tvalid && s_tready;

	// table sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == SLOT_W'(FLOW_ENTRIES - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// write port shared by the sweep and the write-back
	always_comb begin
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = udpfsc_pkg::ST_IDLE;
		end else begin
			ram_we    = adv && valid_s1;
			ram_waddr = slot_s1;
			ram_wdata = res.stage;
		end
	end

	udpfsc_ram #(
		.WIDTH(udpfsc_pkg::STAGE_W),
		.DEPTH(FLOW_ENTRIES)
	) u_stage_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (adv),
		.raddr(in_slot),
		.rdata(rd_stage)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_acc;
			fwd_valid_q <= valid_s1;
		end
	end

	// stage 1 payload and forwarded write
	always_ff @(posedge clk) begin
		if (adv) begin
			slot_s1     <= in_slot;
			flow_s1     <= in_flow;
			start_s1    <= s_tdata[10];
			len_s1      <= s_tdata[26:11];
			word_s1     <= s_tdata[42:27];
			udp_s1      <= s_tuser[0];
			hit_s1      <= s_tuser[1];
			fwd_addr_q  <= slot_s1;
			fwd_stage_q <= res.stage;
		end
	end

	// the entry read may miss the write made at the same edge
	assign cur_stage = (fwd_valid_q && fwd_addr_q == slot_s1) ? fwd_stage_q : rd_stage;

	udpfsc_step u_step (
		.stage_in      (cur_stage),
		.start_flow    (start_s1),
		.is_udp        (udp_s1),
		.payload_length(len_s1),
		.lead_word     (word_s1),
		.http_hit      (hit_s1),
		.res           (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_flow_q    <= flow_s1;
			out_stage_q   <= res.stage;
			out_verdict_q <= res.verdict;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, out_stage_q, out_flow_q};
	assign m_tuser  = out_verdict_q;

endmodule

// File: src/udpfsc_ram.sv
module udpfsc_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/udpfsc_step.sv
module udpfsc_step (
	input  udpfsc_pkg::stage_t                     stage_in,
	input  logic                                   start_flow,
	input  logic                                   is_udp,
	input  logic [udpfsc_pkg::LEN_W-1:0]           payload_length,
	input  logic [udpfsc_pkg::WORD_W-1:0]          lead_word,
	input  logic                                   http_hit,
	output udpfsc_pkg::step_res_t                  res
);

	udpfsc_pkg::stage_t st;
	udpfsc_pkg::stage_t adv_st;
	udpfsc_pkg::stage_t nx;
	logic               adv_ok;
	logic               p16_0c;
	logic               p64_0b;
	logic               p88_15;
	logic               big_15;
	logic               big_c9;
	logic               p88_01;
	logic               p104_02;
	logic               p32_ca;
	logic               p136_66;

	// packet signatures
	always_comb begin
		p16_0c  = payload_length == udpfsc_pkg::L_16  && lead_word == udpfsc_pkg::W_010C;
		p64_0b  = payload_length == udpfsc_pkg::L_64  && lead_word == udpfsc_pkg::W_010B;
		p88_15  = payload_length == udpfsc_pkg::L_88  && lead_word == udpfsc_pkg::W_0115;
		big_15  = payload_length > udpfsc_pkg::L_LARGE && lead_word == udpfsc_pkg::W_0115;
		big_c9  = payload_length == udpfsc_pkg::L_136 &&
			(lead_word == udpfsc_pkg::W_01C9 || lead_word == udpfsc_pkg::W_0165);
		p88_01  = payload_length == udpfsc_pkg::L_88  && lead_word == udpfsc_pkg::W_0101;
		p104_02 = payload_length == udpfsc_pkg::L_104 && lead_word == udpfsc_pkg::W_0102;
		p32_ca  = payload_length == udpfsc_pkg::L_32  && lead_word == udpfsc_pkg::W_01CA;
		p136_66 = payload_length == udpfsc_pkg::L_136 && lead_word == udpfsc_pkg::W_0166;
	end

	// chain walk for a pending flow
	always_comb begin
		st     = start_flow ? udpfsc_pkg::ST_IDLE : stage_in;
		adv_ok = 1'b0;
		adv_st = udpfsc_pkg::ST_DETECTED;
		unique case (st)
			5'd0: begin
				adv_ok = 1'b1;
				priority if (p64_0b)  adv_st = 5'd1;
				else if (big_c9)      adv_st = 5'd4;
				else if (p88_01)      adv_st = 5'd7;
				else if (p104_02)     adv_st = 5'd10;
				else if (p32_ca)      adv_st = 5'd13;
				else if (p16_0c)      adv_st = 5'd16;
				else                  adv_ok = 1'b0;
			end
			5'd1: begin
				adv_ok = big_15;
				adv_st = 5'd2;
			end
			5'd2: begin
				adv_ok = p16_0c || p64_0b || p88_15;
				adv_st = 5'd3;
			end
			5'd3: begin
				adv_ok = p16_0c || p64_0b || big_15;
			end
			5'd4, 5'd5: begin
				adv_ok = big_c9;
				adv_st = st + 5'd1;
			end
			5'd6: begin
				adv_ok = big_c9 || p32_ca;
			end
			5'd7, 5'd8: begin
				adv_ok = p88_01;
				adv_st = st + 5'd1;
			end
			5'd9: begin
				adv_ok = p88_01;
			end
			5'd10, 5'd11: begin
				adv_ok = p104_02;
				adv_st = st + 5'd1;
			end
			5'd12: begin
				adv_ok = p104_02 || p32_ca;
			end
			5'd13: begin
				adv_ok = p32_ca;
				adv_st = 5'd14;
			end
			5'd14: begin
				adv_ok = p32_ca || p136_66;
				adv_st = 5'd15;
			end
			5'd15: begin
				adv_ok = p32_ca || p136_66;
			end
			5'd16, 5'd17: begin
				adv_ok = p16_0c;
				adv_st = st + 5'd1;
			end
			5'd18: begin
				adv_ok = p16_0c;
			end
			default: begin
				adv_ok = 1'b0;
			end
		endcase
	end

	// sticky verdicts and the fallback on no match
	always_comb begin
		if (st < udpfsc_pkg::ST_DETECTED) begin
			if (is_udp && adv_ok) begin
				nx = adv_st;
			end else begin
				nx = http_hit ? udpfsc_pkg::ST_DETECTED : udpfsc_pkg::ST_EXCLUDED;
			end
		end else if (st > udpfsc_pkg::ST_EXCLUDED) begin
			nx = udpfsc_pkg::ST_EXCLUDED;
		end else begin
			nx = st;
		end
		res.stage = nx;
		if (nx == udpfsc_pkg::ST_DETECTED) begin
			res.verdict = udpfsc_pkg::VERDICT_DETECTED;
		end else if (nx == udpfsc_pkg::ST_EXCLUDED) begin
			res.verdict = udpfsc_pkg::VERDICT_EXCLUDED;
		end else begin
			res.verdict = udpfsc_pkg::VERDICT_PENDING;
		end
	end

endmodule

// File: tb/tb.sv
module tb;

	import udpfsc_pkg::*;

	localparam int FLOW_ENTRIES = 1024;
	localparam int LIMIT_CYCLES = 400000;
	localparam int POOL_SIZE    = 24;

	// one packet header as seen on the slave side
	typedef struct packed {
		logic [IDX_W-1:0]  flow;
		logic              start;
		logic              udp;
		logic [LEN_W-1:0]  len;
		logic [WORD_W-1:0] word;
		logic              hit;
	} pkt_t;

	// one flow report as seen on the master side
	typedef struct packed {
		logic [IDX_W-1:0] flow;
		stage_t           stage;
		verdict_t         verdict;
	} flow_report_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// flow_index[9:0], start_flow[10], payload_length[26:11], lead_word[42:27]
	logic [47:0] s_tdata;
	// is_udp[0], http_hit[1]
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// flow_out[9:0], stage_out[14:10]
	logic [15:0] m_tdata;
	// verdict[1:0]
	logic [1:0]  m_tuser;

	stage_t           flow_table [FLOW_ENTRIES];
	flow_report_t     expected_reports [$];
	logic [IDX_W-1:0] flow_pool [POOL_SIZE];
	int               src_idle_pct;
	int               sink_idle_pct;
	int               errors;
	int               cycles;

	udp_flow_signature_classifier #(
		.FLOW_ENTRIES(FLOW_ENTRIES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	function automatic bit pkt_is(input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] word,
			input logic [LEN_W-1:0] want_len, input logic [WORD_W-1:0] want_word);
		return len == want_len && word == want_word;
	endfunction

	// next stage of a signature chain; returns 0 when the packet fits no chain
	function automatic bit chain_advance(input stage_t st, input logic [LEN_W-1:0] len,
			input logic [WORD_W-1:0] word, output stage_t nx);
		bit big_c9;
		bit ok;
		big_c9 = len == L_136 && (word == W_01C9 || word == W_0165);
		ok = 1'b0;
		nx = ST_IDLE;
		case (st)
			5'd0: begin
				ok = 1'b1;
				if (pkt_is(len, word, L_64, W_010B))
					nx = 5'd1;
				else if (big_c9)
					nx = 5'd4;
				else if (pkt_is(len, word, L_88, W_0101))
					nx = 5'd7;
				else if (pkt_is(len, word, L_104, W_0102))
					nx = 5'd10;
				else if (pkt_is(len, word, L_32, W_01CA))
					nx = 5'd13;
				else if (pkt_is(len, word, L_16, W_010C))
					nx = 5'd16;
				else
					ok = 1'b0;
			end
			5'd1: begin
				ok = len > L_LARGE && word == W_0115;
				nx = 5'd2;
			end
			5'd2: begin
				ok = pkt_is(len, word, L_16, W_010C) || pkt_is(len, word, L_64, W_010B) ||
					pkt_is(len, word, L_88, W_0115);
				nx = 5'd3;
			end
			5'd3: begin
				ok = pkt_is(len, word, L_16, W_010C) || pkt_is(len, word, L_64, W_010B) ||
					(len > L_LARGE && word == W_0115);
				nx = ST_DETECTED;
			end
			5'd4, 5'd5: begin
				ok = big_c9;
				nx = st + 5'd1;
			end
			5'd6: begin
				ok = big_c9 || pkt_is(len, word, L_32, W_01CA);
				nx = ST_DETECTED;
			end
			5'd7, 5'd8, 5'd9: begin
				ok = pkt_is(len, word, L_88, W_0101);
				nx = (st == 5'd9) ? ST_DETECTED : st + 5'd1;
			end
			5'd10, 5'd11: begin
				ok = pkt_is(len, word, L_104, W_0102);
				nx = st + 5'd1;
			end
			5'd12: begin
				ok = pkt_is(len, word, L_104, W_0102) || pkt_is(len, word, L_32, W_01CA);
				nx = ST_DETECTED;
			end
			5'd13: begin
				ok = pkt_is(len, word, L_32, W_01CA);
				nx = 5'd14;
			end
			5'd14, 5'd15: begin
				ok = pkt_is(len, word, L_32, W_01CA) || pkt_is(len, word, L_136, W_0166);
				nx = (st == 5'd15) ? ST_DETECTED : 5'd15;
			end
			5'd16, 5'd17, 5'd18: begin
				ok = pkt_is(len, word, L_16, W_010C);
				nx = (st == 5'd18) ? ST_DETECTED : st + 5'd1;
			end
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	// update the flow table for one accepted packet and queue its report
	function automatic void classify_packet(input pkt_t p);
		int           slot;
		stage_t       st;
		stage_t       nx;
		flow_report_t rep;
		slot = p.flow % FLOW_ENTRIES;
		st = p.start ? ST_IDLE : flow_table[slot];
		if (st < ST_DETECTED) begin
			if (p.udp && chain_advance(st, p.len, p.word, nx))
				st = nx;
			else
				st = p.hit ? ST_DETECTED : ST_EXCLUDED;
		end else if (st > ST_EXCLUDED) begin
			st = ST_EXCLUDED;
		end
		flow_table[slot] = st;
		rep.flow = p.flow;
		rep.stage = st;
		if (st == ST_DETECTED)
			rep.verdict = VERDICT_DETECTED;
		else if (st == ST_EXCLUDED)
			rep.verdict = VERDICT_EXCLUDED;
		else
			rep.verdict = VERDICT_PENDING;
		expected_reports.push_back(rep);
	endfunction

	// a (length, lead word) pair that moves a flow on from stage st
	function automatic logic [31:0] chain_pair(input stage_t st);
		logic [LEN_W-1:0] big_len;
		big_len = LEN_W'($urandom_range(65535, 101));
		case (st)
			5'd0: begin
				case ($urandom_range(6))
					0: return {L_64, W_010B};
					1: return {L_136, W_01C9};
					2: return {L_136, W_0165};
					3: return {L_88, W_0101};
					4: return {L_104, W_0102};
					5: return {L_32, W_01CA};
					default: return {L_16, W_010C};
				endcase
			end
			5'd1: return {big_len, W_0115};
			5'd2, 5'd3: begin
				case ($urandom_range(2))
					0: return {L_16, W_010C};
					1: return {L_64, W_010B};
					default: return (st == 5'd2) ? {L_88, W_0115} : {big_len, W_0115};
				endcase
			end
			5'd4, 5'd5, 5'd6: begin
				case ($urandom_range((st == 5'd6) ? 2 : 1))
					0: return {L_136, W_01C9};
					1: return {L_136, W_0165};
					default: return {L_32, W_01CA};
				endcase
			end
			5'd7, 5'd8, 5'd9: return {L_88, W_0101};
			5'd10, 5'd11: return {L_104, W_0102};
			5'd12: return $urandom_range(1) ? {L_104, W_0102} : {L_32, W_01CA};
			5'd13: return {L_32, W_01CA};
			5'd14, 5'd15: return $urandom_range(1) ? {L_32, W_01CA} : {L_136, W_0166};
			default: return {L_16, W_010C};
		endcase
	endfunction

	// payload length near or away from the signature lengths
	function automatic logic [LEN_W-1:0] noise_len();
		case ($urandom_range(9))
			0: return L_16;
			1: return L_32;
			2: return L_64;
			3: return L_88;
			4: return $urandom_range(1) ? L_LARGE : L_LARGE + 16'd1;
			5: return L_104;
			6: return L_136;
			7: return $urandom_range(1) ? 16'd0 : 16'hffff;
			default: return LEN_W'($urandom_range(65535));
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] noise_word();
		case ($urandom_range(11))
			0: return W_010B;
			1: return W_0115;
			2: return W_010C;
			3: return W_01C9;
			4: return W_0165;
			5: return W_0101;
			6: return W_0102;
			7: return W_01CA;
			8: return W_0166;
			default: return WORD_W'($urandom_range(65535));
		endcase
	endfunction

	// mostly well-formed chain packets for a few busy flows, the rest noise
	function automatic pkt_t random_packet();
		pkt_t   p;
		stage_t st;
		if ($urandom_range(99) < 85)
			p.flow = flow_pool[$urandom_range(POOL_SIZE - 1)];
		else
			p.flow = IDX_W'($urandom_range(1023));
		st = flow_table[p.flow % FLOW_ENTRIES];
		if (st >= ST_DETECTED)
			p.start = $urandom_range(99) < 85;
		else
			p.start = $urandom_range(99) < 4;
		if (p.start)
			st = ST_IDLE;
		p.hit = 1'($urandom_range(1));
		if (st < ST_DETECTED && $urandom_range(99) < 80) begin
			p.udp = 1'b1;
			{p.len, p.word} = chain_pair(st);
		end else begin
			p.udp = $urandom_range(9) != 0;
			p.len = noise_len();
			p.word = noise_word();
		end
		return p;
	endfunction

	// offer one word on the slave side, with random gaps, until accepted
	task automatic send_packet(input pkt_t p);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, p.word, p.len, p.start, p.flow};
		s_tuser <= {p.hit, p.udp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		classify_packet(p);
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [IDX_W-1:0] flow, input bit start, input bit udp,
			input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] word, input bit hit);
		pkt_t p;
		p.flow = flow;
		p.start = start;
		p.udp = udp;
		p.len = len;
		p.word = word;
		p.hit = hit;
		send_packet(p);
	endtask

	// stop sending and let the pipeline empty
	task automatic wait_reports_drained();
		s_tvalid <= 1'b0;
		while (expected_reports.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic test_directed_cases();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		// first chain to detection on the top flow, then a sticky repeat
		send_fields(10'd1023, 1'b0, 1'b1, L_64, W_010B, 1'b0);
		send_fields(10'd1023, 1'b0, 1'b1, 16'd101, W_0115, 1'b0);
		send_fields(10'd1023, 1'b0, 1'b1, L_88, W_0115, 1'b0);
		send_fields(10'd1023, 1'b0, 1'b1, 16'hffff, W_0115, 1'b0);
		send_fields(10'd1023, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0);
		// non-udp with and without the upstream hit
		send_fields(10'd0, 1'b0, 1'b0, L_64, W_010B, 1'b1);
		send_fields(10'd0, 1'b1, 1'b0, L_64, W_010B, 1'b0);
		// no chain match with and without the upstream hit
		send_fields(10'd5, 1'b0, 1'b1, 16'hffff, 16'hffff, 1'b1);
		send_fields(10'd6, 1'b0, 1'b1, 16'd0, 16'd0, 1'b0);
		// length exactly at the large bound does not count as large
		send_fields(10'd2, 1'b0, 1'b1, L_64, W_010B, 1'b1);
		send_fields(10'd2, 1'b0, 1'b1, L_LARGE, W_0115, 1'b0);
		// start bit lifts an excluded flow back into a chain
		send_fields(10'd2, 1'b1, 1'b1, L_16, W_010C, 1'b0);
		// start bit clears a detected flow, then the 136-byte chain
		send_fields(10'd1023, 1'b1, 1'b1, L_136, W_01C9, 1'b0);
		send_fields(10'd1023, 1'b0, 1'b1, L_136, W_0165, 1'b0);
		send_fields(10'd1023, 1'b0, 1'b1, L_136, W_01C9, 1'b0);
		send_fields(10'd1023, 1'b0, 1'b1, L_32, W_01CA, 1'b0);
		// 32-byte chain with the 0x0166 alternatives
		send_fields(10'd512, 1'b0, 1'b1, L_32, W_01CA, 1'b1);
		send_fields(10'd512, 1'b0, 1'b1, L_32, W_01CA, 1'b0);
		send_fields(10'd512, 1'b0, 1'b1, L_136, W_0166, 1'b1);
		send_fields(10'd512, 1'b0, 1'b1, L_136, W_0166, 1'b0);
		// sticky exclusion survives a matching packet
		send_fields(10'd6, 1'b0, 1'b1, L_64, W_010B, 1'b1);
	endtask

	task automatic test_chain_traffic(input int src_pct, input int sink_pct, input int n);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		repeat (n)
			send_packet(random_packet());
	endtask

	task automatic test_drain_pause();
		repeat (30)
			send_packet(random_packet());
		wait_reports_drained();
		repeat (30)
			send_packet(random_packet());
	endtask

	// compare each result word with the oldest expected report
	always @(posedge clk) begin : check_reports
		flow_report_t want;
		if (m_tvalid && m_tready) begin
			if (expected_reports.size() == 0) begin
				$error("unexpected result word for flow_out %0d", m_tdata[IDX_W-1:0]);
				errors++;
			end else begin
				want = expected_reports.pop_front();
				if (m_tdata[IDX_W-1:0] !== want.flow) begin
					$error("flow_out: expected %0d, actual %0d", want.flow, m_tdata[IDX_W-1:0]);
					errors++;
				end
				if (m_tdata[IDX_W+STAGE_W-1:IDX_W] !== want.stage) begin
					$error("stage_out: expected %0d, actual %0d", want.stage,
						m_tdata[IDX_W+STAGE_W-1:IDX_W]);
					errors++;
				end
				if (m_tuser !== want.verdict) begin
					$error("verdict: expected %0d, actual %0d", want.verdict, m_tuser);
					errors++;
				end
			end
		end
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		errors = 0;
		cycles = 0;
		for (int i = 0; i < FLOW_ENTRIES; i++)
			flow_table[i] = ST_IDLE;
		flow_pool[0] = 10'd0;
		flow_pool[1] = 10'd1023;
		for (int i = 2; i < POOL_SIZE; i++)
			flow_pool[i] = IDX_W'($urandom_range(1023));
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_chain_traffic(7, 83, 200);
		test_drain_pause();
		test_chain_traffic(83, 7, 170);
		test_chain_traffic(0, 0, 200);

		sink_idle_pct = 0;
		wait_reports_drained();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
src/udpfsc_pkg.sv
src/udpfsc_ram.sv
src/udpfsc_step.sv
src/udp_flow_signature_classifier.sv
tb/tb.sv
